@@ src/gif_frame_compositor_defines.svh @@
// Assertion macros shared by the compositor RTL.
`ifndef GIF_FRAME_COMPOSITOR_DEFINES_SVH
`define GIF_FRAME_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GFC_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("compositor check failed (same cycle)");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GFC_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("compositor check failed (next cycle)");

`endif

@@ src/gfc_pkg.sv @@
// Shared types, codes and constant tables of the frame compositor.
package gfc_pkg;

    localparam int MAX_SIDE_DEF      = 256;
    localparam int PALETTE_DEPTH_DEF = 256;

    // coordinate, column and row widths
    localparam int COORD_W = 11;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 10;

    // configuration register indexes
    localparam logic [3:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [3:0] REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [8:0] SCREEN_SIDE_RESET = 9'd256;

    // request opcodes
    localparam logic [2:0] OP_PALETTE = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_PIXEL   = 3'd2;
    localparam logic [2:0] OP_END     = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // disposal codes
    localparam logic [1:0] DISP_BACKGROUND = 2'd2;
    localparam logic [1:0] DISP_PREVIOUS   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE   = 2'd1;
    localparam logic [1:0] STATUS_OFF_SCREEN = 2'd2;

    localparam logic [1:0] LAST_PASS = 2'd3;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PIX   = 6'b000100,
        S_READ  = 6'b001000,
        S_WALK  = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        W_SAVE    = 2'd0,
        W_CLEAR   = 2'd1,
        W_RESTORE = 2'd2
    } walk_mode_t;

    // raster position inside the frame rectangle
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       pass;
    } raster_pos_t;

    // first row of each interlace pass
    function automatic logic [3:0] pass_start(input logic [1:0] p);
        case (p)
            2'd0:    return 4'd0;
            2'd1:    return 4'd4;
            2'd2:    return 4'd2;
            default: return 4'd1;
        endcase
    endfunction

    // row step of each interlace pass
    function automatic logic [3:0] pass_step(input logic [1:0] p);
        case (p)
            2'd0:    return 4'd8;
            2'd1:    return 4'd8;
            2'd2:    return 4'd4;
            default: return 4'd2;
        endcase
    endfunction

endpackage

@@ src/gif_frame_compositor.sv @@
// Top level of the frame compositor: screen, saved copy and palette memories.
//
// Requests enter on s_* (opcode in s_tuser), one result per request leaves on m_*.
// Configuration writes (screen width/height) use cfg_*; cfg_ready is always high,
// so write them only while no request is in flight.
// A result register parts the two sides: a new request is taken while the
// previous result is being taken in the same cycle.
// Steps of each request, accept to result register:
//   palette write, frame start, off-screen or skipped pixel, off-screen read,
//   frame end with no frame, unknown: result registered on accept
//   pixel written to screen: palette memory read, then screen write
//   read pixel: screen memory read, then result
//   frame end, clear or restore: frame width * height entries, one entry a cycle
//   frame end, save: MAX_SIDE * MAX_SIDE entries (whole screen copied entry by entry)
// Frame-end time is set by the single write port of the screen/saved memories.
// After reset the screen memory is cleared entry by entry, all MAX_SIDE * MAX_SIDE
// entries (65536 by default); no request is taken then, configuration writes are.
// When m_tready is low the result holds and s_tready drops until it is taken.
module gif_frame_compositor
    import gfc_pkg::*;
#(
    parameter int MAX_SIDE      = MAX_SIDE_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // color_index[7:0], color_rgb[31:8], frame_left[39:32], frame_top[47:40],
    // frame_width[56:48], frame_height[65:57], transparent_index[74:66],
    // disposal_mode[76:75], interlaced[77], zero fill[79:78]
    input  logic [79:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_rgb[23:0], pixel_opaque[24], status[26:25], zero fill[31:27]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    `include "gif_frame_compositor_defines.svh"

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // request fields
    logic [2:0]  opcode;
    logic [7:0]  color_index;
    logic [23:0] color_rgb;
    logic [7:0]  frame_left;
    logic [7:0]  frame_top;
    logic [8:0]  frame_width;
    logic [8:0]  frame_height;
    logic [8:0]  transparent_index;
    logic [1:0]  disposal_mode;
    logic        interlaced;

    assign opcode            = s_tuser;
    assign color_index       = s_tdata[7:0];
    assign color_rgb         = s_tdata[31:8];
    assign frame_left        = s_tdata[39:32];
    assign frame_top         = s_tdata[47:40];
    assign frame_width       = s_tdata[56:48];
    assign frame_height      = s_tdata[65:57];
    assign transparent_index = s_tdata[74:66];
    assign disposal_mode     = s_tdata[76:75];
    assign interlaced        = s_tdata[77];

    // control registers
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             wd_valid_reg, wd_valid_next;
    logic [8:0]       scr_w_reg, scr_w_next;
    logic [8:0]       scr_h_reg, scr_h_next;
    logic [7:0]       geo_left_reg, geo_left_next;
    logic [7:0]       geo_top_reg, geo_top_next;
    logic [8:0]       geo_w_reg, geo_w_next;
    logic [8:0]       geo_h_reg, geo_h_next;
    logic             trans_en_reg, trans_en_next;
    logic [7:0]       trans_idx_reg, trans_idx_next;
    logic [1:0]       disp_reg, disp_next;
    logic             intl_reg, intl_next;
    raster_pos_t      pos_reg, pos_next;
    logic             saved_valid_reg, saved_valid_next;

    // payload registers
    logic [23:0]      out_rgb_reg, out_rgb_next;
    logic             out_opq_reg, out_opq_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [AW-1:0]    pix_addr_reg, pix_addr_next;
    logic             pix_pal_ok_reg, pix_pal_ok_next;
    walk_mode_t       walk_mode_reg, walk_mode_next;
    logic [COORD_W-1:0] walk_x_reg, walk_x_next;
    logic [COORD_W-1:0] walk_y_reg, walk_y_next;
    logic [COORD_W-1:0] walk_left_reg, walk_left_next;
    logic [COORD_W-1:0] walk_top_reg, walk_top_next;
    logic [COORD_W-1:0] walk_w_reg, walk_w_next;
    logic [COORD_W-1:0] walk_h_reg, walk_h_next;
    logic [AW-1:0]    wd_addr_reg, wd_addr_next;

    // memories and their ports
    logic [24:0] screen_mem [DEPTH];
    logic [24:0] saved_mem  [DEPTH];
    logic [23:0] pal_mem    [PALETTE_DEPTH];
    logic [24:0] scr_rdata_reg;
    logic [24:0] sav_rdata_reg;
    logic [23:0] pal_rdata_reg;
    logic        scr_we;
    logic [AW-1:0] scr_waddr, scr_raddr;
    logic [24:0] scr_wdata;
    logic        sav_we;
    logic [AW-1:0] sav_waddr;
    logic [24:0] sav_wdata;
    logic        pal_we;

    logic        accept;
    logic        busy;
    logic [COORD_W-1:0] eff_w, eff_h;
    logic [COORD_W-1:0] psx, psy, wsx, wsy;
    logic [AW-1:0] walk_addr;
    logic        w_on, walk_last;
    logic        pix_live, pix_trans, pix_on, read_on, frame_bad, pal_in_range;
    raster_pos_t pos_adv;

    function automatic logic [AW-1:0] scr_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
        logic [31:0] t;
        t = 32'(y) * 32'(MAX_SIDE) + 32'(x);
        return t[AW-1:0];
    endfunction

    function automatic logic on_scr(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y,
                                    input logic [COORD_W-1:0] ew,
                                    input logic [COORD_W-1:0] eh);
        return (x < ew) && (y < eh);
    endfunction

    gfc_raster u_raster (
        .pos        (pos_reg),
        .width      (geo_w_reg),
        .height     (geo_h_reg),
        .interlaced (intl_reg),
        .next       (pos_adv)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_status_reg, out_opq_reg, out_rgb_reg};
    assign busy      = (state_reg == S_PIX) || (state_reg == S_READ) ||
                       (state_reg == S_WALK) || (state_reg == S_DRAIN);

    // effective screen size, capped at the store side
    assign eff_w = ({2'b00, scr_w_reg} > COORD_W'(MAX_SIDE)) ? COORD_W'(MAX_SIDE)
                                                             : {2'b00, scr_w_reg};
    assign eff_h = ({2'b00, scr_h_reg} > COORD_W'(MAX_SIDE)) ? COORD_W'(MAX_SIDE)
                                                             : {2'b00, scr_h_reg};

    // pixel request decode
    assign pix_live     = (geo_w_reg != '0) && (pos_reg.row < {1'b0, geo_h_reg});
    assign pix_trans    = trans_en_reg && (color_index == trans_idx_reg);
    assign psx          = COORD_W'(geo_left_reg) + COORD_W'(pos_reg.col);
    assign psy          = COORD_W'(geo_top_reg) + COORD_W'(pos_reg.row);
    assign pix_on       = on_scr(psx, psy, eff_w, eff_h);
    assign pal_in_range = 32'(color_index) < 32'(PALETTE_DEPTH);
    assign read_on      = on_scr(COORD_W'(frame_left), COORD_W'(frame_top), eff_w, eff_h);
    assign frame_bad    = (frame_width == '0) || (frame_height == '0) ||
                          (32'(frame_width) > 32'(MAX_SIDE)) ||
                          (32'(frame_height) > 32'(MAX_SIDE));

    // disposal walk position
    assign wsx       = walk_left_reg + walk_x_reg;
    assign wsy       = walk_top_reg + walk_y_reg;
    assign walk_addr = scr_addr(wsx, wsy);
    assign w_on      = (walk_mode_reg == W_SAVE) || on_scr(wsx, wsy, eff_w, eff_h);
    assign walk_last = (walk_x_reg == walk_w_reg - 1'b1) &&
                       (walk_y_reg == walk_h_reg - 1'b1);

    // memory port selection
    always_comb
    begin
        scr_we    = 1'b0;
        scr_waddr = wd_addr_reg;
        scr_wdata = '0;
        sav_we    = 1'b0;
        sav_waddr = wd_addr_reg;
        sav_wdata = scr_rdata_reg;
        scr_raddr = (state_reg == S_IDLE) ? scr_addr(COORD_W'(frame_left), COORD_W'(frame_top))
                                          : walk_addr;
        pal_we    = accept && (opcode == OP_PALETTE) && pal_in_range;
        case (state_reg)
            S_CLEAR:
            begin
                scr_we    = 1'b1;
                scr_waddr = clr_cnt_reg;
            end
            S_PIX:
            begin
                scr_we    = 1'b1;
                scr_waddr = pix_addr_reg;
                scr_wdata = {1'b1, pix_pal_ok_reg ? pal_rdata_reg : 24'd0};
            end
            S_WALK, S_DRAIN:
            begin
                // delayed write stage of the walk
                if (wd_valid_reg)
                begin
                    if (walk_mode_reg == W_SAVE)
                    begin
                        sav_we = 1'b1;
                    end
                    else
                    begin
                        scr_we    = 1'b1;
                        scr_wdata = (walk_mode_reg == W_RESTORE) ? sav_rdata_reg : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        scr_rdata_reg <= screen_mem[scr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sav_we)
        begin
            saved_mem[sav_waddr] <= sav_wdata;
        end
        sav_rdata_reg <= saved_mem[walk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[color_index[PW-1:0]] <= color_rgb;
        end
        pal_rdata_reg <= pal_mem[color_index[PW-1:0]];
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        wd_valid_next    = wd_valid_reg;
        scr_w_next       = scr_w_reg;
        scr_h_next       = scr_h_reg;
        geo_left_next    = geo_left_reg;
        geo_top_next     = geo_top_reg;
        geo_w_next       = geo_w_reg;
        geo_h_next       = geo_h_reg;
        trans_en_next    = trans_en_reg;
        trans_idx_next   = trans_idx_reg;
        disp_next        = disp_reg;
        intl_next        = intl_reg;
        pos_next         = pos_reg;
        saved_valid_next = saved_valid_reg;
        out_rgb_next     = out_rgb_reg;
        out_opq_next     = out_opq_reg;
        out_status_next  = out_status_reg;
        pix_addr_next    = pix_addr_reg;
        pix_pal_ok_next  = pix_pal_ok_reg;
        walk_mode_next   = walk_mode_reg;
        walk_x_next      = walk_x_reg;
        walk_y_next      = walk_y_reg;
        walk_left_next   = walk_left_reg;
        walk_top_next    = walk_top_reg;
        walk_w_next      = walk_w_reg;
        walk_h_next      = walk_h_reg;
        wd_addr_next     = wd_addr_reg;

        // configuration writes
        if (cfg_valid && cfg_index == REG_SCREEN_WIDTH)
        begin
            scr_w_next = cfg_data;
        end
        if (cfg_valid && cfg_index == REG_SCREEN_HEIGHT)
        begin
            scr_h_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    // default result: zero colour, ok
                    out_valid_next  = 1'b1;
                    out_rgb_next    = '0;
                    out_opq_next    = 1'b0;
                    out_status_next = STATUS_OK;
                    case (opcode)
                        OP_START:
                        begin
                            geo_w_next    = '0;
                            geo_h_next    = '0;
                            geo_left_next = '0;
                            geo_top_next  = '0;
                            trans_en_next = 1'b0;
                            disp_next     = '0;
                            intl_next     = 1'b0;
                            pos_next      = '0;
                            if (frame_bad)
                            begin
                                out_status_next = STATUS_BAD_SIZE;
                            end
                            else
                            begin
                                geo_left_next  = frame_left;
                                geo_top_next   = frame_top;
                                geo_w_next     = frame_width;
                                geo_h_next     = frame_height;
                                trans_en_next  = !transparent_index[8];
                                trans_idx_next = transparent_index[7:0];
                                disp_next      = disposal_mode;
                                intl_next      = interlaced;
                            end
                        end
                        OP_PIXEL:
                        begin
                            if (pix_live)
                            begin
                                pos_next = pos_adv;
                                if (!pix_trans)
                                begin
                                    if (pix_on)
                                    begin
                                        out_valid_next  = 1'b0;
                                        pix_addr_next   = scr_addr(psx, psy);
                                        pix_pal_ok_next = pal_in_range;
                                        state_next      = S_PIX;
                                    end
                                    else
                                    begin
                                        out_status_next = STATUS_OFF_SCREEN;
                                    end
                                end
                            end
                        end
                        OP_END:
                        begin
                            if (geo_w_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                walk_x_next    = '0;
                                walk_y_next    = '0;
                                wd_valid_next  = 1'b0;
                                walk_left_next = COORD_W'(geo_left_reg);
                                walk_top_next  = COORD_W'(geo_top_reg);
                                walk_w_next    = COORD_W'(geo_w_reg);
                                walk_h_next    = COORD_W'(geo_h_reg);
                                if (disp_reg == DISP_BACKGROUND)
                                begin
                                    walk_mode_next = W_CLEAR;
                                end
                                else if (disp_reg == DISP_PREVIOUS)
                                begin
                                    walk_mode_next = saved_valid_reg ? W_RESTORE : W_CLEAR;
                                end
                                else
                                begin
                                    // save copies the whole store
                                    walk_mode_next   = W_SAVE;
                                    walk_left_next   = '0;
                                    walk_top_next    = '0;
                                    walk_w_next      = COORD_W'(MAX_SIDE);
                                    walk_h_next      = COORD_W'(MAX_SIDE);
                                    saved_valid_next = 1'b1;
                                end
                                geo_w_next    = '0;
                                geo_h_next    = '0;
                                geo_left_next = '0;
                                geo_top_next  = '0;
                                trans_en_next = 1'b0;
                                disp_next     = '0;
                                intl_next     = 1'b0;
                                pos_next      = '0;
                                state_next    = S_WALK;
                            end
                        end
                        OP_READ:
                        begin
                            if (read_on)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                            else
                            begin
                                out_status_next = STATUS_OFF_SCREEN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PIX:
            begin
                out_valid_next  = 1'b1;
                out_rgb_next    = '0;
                out_opq_next    = 1'b0;
                out_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                out_rgb_next    = scr_rdata_reg[23:0];
                out_opq_next    = scr_rdata_reg[24];
                out_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end
            S_WALK:
            begin
                // issue stage: read at this entry, write it back next cycle
                wd_valid_next = w_on;
                wd_addr_next  = walk_addr;
                if (walk_x_reg == walk_w_reg - 1'b1)
                begin
                    walk_x_next = '0;
                    walk_y_next = walk_y_reg + 1'b1;
                end
                else
                begin
                    walk_x_next = walk_x_reg + 1'b1;
                end
                if (walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                wd_valid_next   = 1'b0;
                out_valid_next  = 1'b1;
                out_rgb_next    = '0;
                out_opq_next    = 1'b0;
                out_status_next = STATUS_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            wd_valid_reg    <= 1'b0;
            scr_w_reg       <= SCREEN_SIDE_RESET;
            scr_h_reg       <= SCREEN_SIDE_RESET;
            geo_left_reg    <= '0;
            geo_top_reg     <= '0;
            geo_w_reg       <= '0;
            geo_h_reg       <= '0;
            trans_en_reg    <= 1'b0;
            trans_idx_reg   <= '0;
            disp_reg        <= '0;
            intl_reg        <= 1'b0;
            pos_reg         <= '0;
            saved_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            wd_valid_reg    <= wd_valid_next;
            scr_w_reg       <= scr_w_next;
            scr_h_reg       <= scr_h_next;
            geo_left_reg    <= geo_left_next;
            geo_top_reg     <= geo_top_next;
            geo_w_reg       <= geo_w_next;
            geo_h_reg       <= geo_h_next;
            trans_en_reg    <= trans_en_next;
            trans_idx_reg   <= trans_idx_next;
            disp_reg        <= disp_next;
            intl_reg        <= intl_next;
            pos_reg         <= pos_next;
            saved_valid_reg <= saved_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_rgb_reg    <= out_rgb_next;
        out_opq_reg    <= out_opq_next;
        out_status_reg <= out_status_next;
        pix_addr_reg   <= pix_addr_next;
        pix_pal_ok_reg <= pix_pal_ok_next;
        walk_mode_reg  <= walk_mode_next;
        walk_x_reg     <= walk_x_next;
        walk_y_reg     <= walk_y_next;
        walk_left_reg  <= walk_left_next;
        walk_top_reg   <= walk_top_next;
        walk_w_reg     <= walk_w_next;
        walk_h_reg     <= walk_h_next;
        wd_addr_reg    <= wd_addr_next;
    end

    // checks
    `GFC_ASSERT_IMP(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready)
    `GFC_ASSERT_IMP(a_pix_follows_accept, state_reg == S_PIX, $past(accept))
    `GFC_ASSERT_IMP(a_busy_result_empty, busy, !out_valid_reg)
    `GFC_ASSERT_NXT(a_drain_posts, state_reg == S_DRAIN, (state_reg == S_IDLE) && out_valid_reg)

endmodule

@@ src/gfc_raster.sv @@
// Raster position advance for plain and four-pass interlaced frames.
module gfc_raster
    import gfc_pkg::*;
(
    input  raster_pos_t pos,
    input  logic [8:0]  width,
    input  logic [8:0]  height,
    input  logic        interlaced,
    output raster_pos_t next
);

    logic [COL_W:0]   col_inc;
    logic [ROW_W-1:0] row_w;
    logic [1:0]       pass_w;

    always_comb
    begin
        next    = pos;
        col_inc = {1'b0, pos.col} + 1'b1;
        row_w   = pos.row + ROW_W'(pass_step(pos.pass));
        pass_w  = pos.pass;
        if (col_inc < {1'b0, width})
        begin
            next.col = col_inc[COL_W-1:0];
        end
        else
        begin
            next.col = '0;
            if (interlaced)
            begin
                // skip passes that start below the rectangle
                for (int i = 0; i < 3; i++)
                begin
                    if (row_w >= {1'b0, height} && pass_w != LAST_PASS)
                    begin
                        pass_w = pass_w + 2'd1;
                        row_w  = ROW_W'(pass_start(pass_w));
                    end
                end
                next.row  = row_w;
                next.pass = pass_w;
            end
            else
            begin
                next.row = pos.row + 1'b1;
            end
        end
    end

endmodule
